// ===== rtl/core/search_transposition_table_assert.svh =====
// Assertion macros for the transposition table RTL.
`ifndef SEARCH_TRANSPOSITION_TABLE_ASSERT_SVH
`define SEARCH_TRANSPOSITION_TABLE_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

	localparam int MAX_INDEX_BITS = 16;
	localparam int ADDR_W         = MAX_INDEX_BITS;
	localparam int ENTRIES        = 1 << MAX_INDEX_BITS;

	localparam int S_TDATA_W = 144;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 15;

	typedef enum logic [1:0] {
		OP_PROBE = 2'd0,
		OP_STORE = 2'd1,
		OP_AGE   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_UPPER = 2'd1;
	localparam logic [1:0] BOUND_LOWER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MATE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 2'd1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EVAL,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [63:0]        key;
		logic signed [15:0] score;
		logic [6:0]         depth;
		logic [15:0]        move;
		logic [1:0]         bound;
	} entry_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/search_transposition_table.sv =====
// Probe and store: accept with memory read, then evaluate and write back; next item taken after.
// Result is registered; it is loaded from the evaluate state once the output register is free.
// Age and clear walk all 2^MAX_INDEX_BITS entries, one per cycle, then return a zero result.
// After reset a clearing pass over all 2^MAX_INDEX_BITS entries zeroes the table; s_tready stays low.
// Configuration writes are taken at any time and reset to mate limit 30000, index_bits 16.
`default_nettype none
`include "search_transposition_table_assert.svh"

module search_transposition_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// key[63:0], ply[70:64], depth[77:71], alpha[93:78], beta[109:94],
	// value[125:110], move_in[141:126], zero pad [143:142]
	input  wire logic [stt_pkg::S_TDATA_W-1:0]  s_tdata,
	// operation[1:0], bound_kind[3:2]
	input  wire logic [stt_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// score[15:0], move_out[31:16]
	output logic [stt_pkg::M_TDATA_W-1:0]       m_tdata,
	// score_valid[0], move_valid[1], written[2]
	output logic [stt_pkg::M_TUSER_W-1:0]       m_tuser,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [stt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [stt_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import stt_pkg::*;

	entry_t data_mem [ENTRIES];
	logic   valid_mem [ENTRIES];

	state_t state_q, state_d;

	logic [14:0]       mate_thr_q;
	logic [4:0]        index_bits_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	op_t                op_q;
	logic [63:0]        key_q;
	logic [6:0]         ply_q;
	logic [6:0]         depth_q;
	logic signed [15:0] alpha_q;
	logic signed [15:0] beta_q;
	logic [1:0]         bound_q;
	logic [15:0]        move_q;
	logic signed [15:0] store_score_q;
	logic [ADDR_W-1:0]  slot_q;
	entry_t             rd_entry_q;
	logic               rd_valid_q;

	logic               accept;
	logic               out_free;
	logic               enabled;
	logic [4:0]         bits_eff;
	logic [ADDR_W-1:0]  mask;
	logic [ADDR_W-1:0]  rd_addr;
	logic [63:0]        in_key;
	logic [6:0]         in_ply;
	logic signed [17:0] in_value;
	logic signed [17:0] mt_s;
	logic signed [17:0] store_v;
	logic               sweep_on;
	logic               sweep_last;
	logic               sweep_data;
	logic               data_we;
	logic               valid_we;
	logic [ADDR_W-1:0]  wr_addr;
	entry_t             wr_entry;
	logic               wr_valid;
	logic               load_res;
	logic               hit;
	logic               do_write;
	logic signed [17:0] raw;
	logic signed [17:0] adj;
	logic signed [15:0] adj16;
	logic               res_sv;
	logic signed [15:0] res_sc;
	logic               res_mv;
	logic [15:0]        res_mo;
	logic               res_wr;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign enabled  = (index_bits_q != 5'd0);
	assign bits_eff = (index_bits_q > 5'(MAX_INDEX_BITS)) ? 5'(MAX_INDEX_BITS) : index_bits_q;
	assign mask     = ~({ADDR_W{1'b1}} << bits_eff);
	assign in_key   = s_tdata[63:0];
	assign in_ply   = s_tdata[70:64];
	assign in_value = 18'($signed(s_tdata[125:110]));
	assign rd_addr  = in_key[ADDR_W-1:0] & mask;
	assign mt_s     = $signed({3'b000, mate_thr_q});

	always_comb begin
		store_v = in_value;
		if (in_value > mt_s) begin
			store_v = in_value + $signed({11'd0, in_ply});
		end else if (in_value < -mt_s) begin
			store_v = in_value - $signed({11'd0, in_ply});
		end
	end

	// probe and store evaluation on the read entry
	always_comb begin
		hit      = enabled && rd_valid_q && (rd_entry_q.key == key_q);
		do_write = enabled && !((rd_entry_q.key == key_q) && (rd_entry_q.depth > depth_q));
		raw      = 18'($signed(rd_entry_q.score));
		adj      = raw;
		if (adj > mt_s) begin
			adj = adj - $signed({11'd0, ply_q});
		end
		if (adj < -mt_s) begin
			adj = adj + $signed({11'd0, ply_q});
		end
		adj16  = sat16(adj);
		res_sv = 1'b0;
		res_sc = '0;
		res_mv = 1'b0;
		res_mo = '0;
		res_wr = 1'b0;
		if (state_q == ST_EVAL) begin
			if (op_q == OP_PROBE) begin
				if (hit) begin
					res_mv = 1'b1;
					res_mo = rd_entry_q.move;
					if (rd_entry_q.depth >= depth_q) begin
						if (rd_entry_q.bound == BOUND_EXACT) begin
							res_sv = 1'b1;
							res_sc = adj16;
						end else if (rd_entry_q.bound == BOUND_UPPER &&
						             $signed(rd_entry_q.score) <= alpha_q) begin
							res_sv = 1'b1;
							res_sc = alpha_q;
						end else if (rd_entry_q.bound == BOUND_LOWER &&
						             $signed(rd_entry_q.score) >= beta_q) begin
							res_sv = 1'b1;
							res_sc = beta_q;
						end
					end
				end
			end else begin
				res_wr = do_write;
			end
		end
	end

	assign sweep_last = (sweep_q == {ADDR_W{1'b1}});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser[1:0] == OP_PROBE || s_tuser[1:0] == OP_STORE) begin
						state_d = ST_EVAL;
					end else begin
						state_d = ST_SWEEP;
					end
				end
			end
			ST_EVAL: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (sweep_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		sweep_on   = 1'b0;
		sweep_data = 1'b0;
		load_res   = 1'b0;
		data_we    = 1'b0;
		valid_we   = 1'b0;
		wr_addr    = slot_q;
		wr_entry   = '{key: key_q, score: store_score_q, depth: depth_q,
		               move: move_q, bound: bound_q};
		wr_valid   = 1'b1;
		case (state_q)
			ST_INIT: begin
				sweep_on   = 1'b1;
				sweep_data = 1'b1;
			end
			ST_SWEEP: begin
				sweep_on   = 1'b1;
				sweep_data = (op_q == OP_CLEAR);
			end
			ST_EVAL: begin
				load_res = out_free;
				if (out_free && op_q == OP_STORE && do_write) begin
					data_we  = 1'b1;
					valid_we = 1'b1;
				end
			end
			ST_DONE: begin
				load_res = out_free;
			end
			default: begin
			end
		endcase
		if (sweep_on) begin
			wr_addr  = sweep_q;
			wr_entry = '0;
			wr_valid = 1'b0;
			data_we  = sweep_data;
			valid_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			sweep_q      <= '0;
			mate_thr_q   <= 15'd30000;
			index_bits_q <= 5'd16;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sweep_on) sweep_q <= sweep_q + 1'b1;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MATE_LIMIT: mate_thr_q <= cfg_data;
					CFG_INDEX_BITS: index_bits_q <= cfg_data[4:0];
					default: begin
					end
				endcase
			end
			if (load_res) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q          <= op_t'(s_tuser[1:0]);
			bound_q       <= s_tuser[3:2];
			key_q         <= in_key;
			ply_q         <= in_ply;
			depth_q       <= s_tdata[77:71];
			alpha_q       <= $signed(s_tdata[93:78]);
			beta_q        <= $signed(s_tdata[109:94]);
			move_q        <= s_tdata[141:126];
			store_score_q <= sat16(store_v);
			slot_q        <= rd_addr;
		end
		if (load_res) begin
			m_tdata_q <= {res_mo, res_sc};
			m_tuser_q <= {res_wr, res_mv, res_sv};
		end
	end

	always_ff @(posedge clk) begin
		if (data_we) data_mem[wr_addr] <= wr_entry;
		if (valid_we) valid_mem[wr_addr] <= wr_valid;
		if (accept) begin
			rd_entry_q <= data_mem[rd_addr];
			rd_valid_q <= valid_mem[rd_addr];
		end
	end

	`STT_ASSERT_NEXT(a_rmw_next, accept && (s_tuser[1:0] == OP_PROBE || s_tuser[1:0] == OP_STORE), state_q == ST_EVAL, "probe or store did not enter evaluation")
	`STT_ASSERT_NOW(a_wr_store, load_res && res_wr, op_q == OP_STORE && state_q == ST_EVAL, "written flag without a store")
	`STT_ASSERT_NOW(a_score_hit, m_tvalid && m_tuser[0], m_tuser[1], "score without a hit")
	`STT_ASSERT_NEXT(a_sweep_step, state_q == ST_SWEEP && !sweep_last, sweep_q == ADDR_W'($past(sweep_q) + 1'b1), "sweep counter skipped")

endmodule

`default_nettype wire

// ===== tb/sv/search_transposition_table_tb.sv =====
module search_transposition_table_tb;
	import stt_pkg::*;

	typedef struct packed {
		op_t                op;
		logic [63:0]        key;
		logic [6:0]         ply;
		logic [6:0]         depth;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic signed [15:0] value;
		logic [1:0]         bound;
		logic [15:0]        move;
	} tt_req_t;

	typedef struct packed {
		logic               score_valid;
		logic signed [15:0] score;
		logic               move_valid;
		logic [15:0]        move_out;
		logic               written;
	} tt_res_t;

	localparam logic [63:0] KEY_A  = 64'hfedc_ba98_7654_3210;
	localparam logic [63:0] KEY_AC = 64'h0123_4567_89ab_3210;
	localparam logic [63:0] KEY_B  = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] KEY_Z  = 64'h0;
	localparam logic [1:0]  BOUND_ODD = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	search_transposition_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow table
	bit [63:0] tt_key   [ENTRIES];
	bit [15:0] tt_score [ENTRIES];
	bit [6:0]  tt_depth [ENTRIES];
	bit [15:0] tt_move  [ENTRIES];
	bit [1:0]  tt_bound [ENTRIES];
	bit        tt_valid [ENTRIES];
	logic [14:0] mate_thr = 15'd30000;
	logic [4:0]  idx_bits = 5'd16;

	tt_req_t request_q [$];
	tt_res_t due_results [$];
	logic [63:0] key_pool [24];
	logic [63:0] last_stored_key = '0;
	logic item_taken = 1'b0;
	int n_queued = 0;
	int n_accepted = 0;
	int n_hits = 0;
	int n_scored = 0;
	int n_written = 0;
	int n_walks = 0;
	int walks_left = 4;
	int fails = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int phase_mt [8] = '{0, 32767, 30000, 30000, 1000, 12345, 29000, 30000};
	int phase_ib [8] = '{16, 16, 4, 0, 31, 1, 20, 16};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#48000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic tt_res_t table_access(input tt_req_t r);
		tt_res_t res;
		int bits;
		int slot;
		int mt;
		int raw;
		int adj;
		res = '0;
		mt = int'(mate_thr);
		bits = (idx_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(idx_bits);
		slot = int'(r.key & ((64'd1 << bits) - 64'd1));
		case (r.op)
			OP_PROBE: begin
				if (idx_bits != 0 && tt_valid[slot] && tt_key[slot] == r.key) begin
					raw = int'($signed(tt_score[slot]));
					res.move_valid = 1'b1;
					res.move_out = tt_move[slot];
					if (tt_depth[slot] >= r.depth) begin
						adj = raw;
						if (adj > mt)
							adj = adj - int'(r.ply);
						if (adj < -mt)
							adj = adj + int'(r.ply);
						adj = clamp16(adj);
						if (tt_bound[slot] == BOUND_EXACT) begin
							res.score_valid = 1'b1;
							res.score = adj[15:0];
						end else if (tt_bound[slot] == BOUND_UPPER &&
								raw <= int'($signed(r.alpha))) begin
							res.score_valid = 1'b1;
							res.score = r.alpha;
						end else if (tt_bound[slot] == BOUND_LOWER &&
								raw >= int'($signed(r.beta))) begin
							res.score_valid = 1'b1;
							res.score = r.beta;
						end
					end
				end
			end
			OP_STORE: begin
				if (idx_bits != 0 && !(tt_key[slot] == r.key && tt_depth[slot] > r.depth)) begin
					adj = int'($signed(r.value));
					if (adj > mt)
						adj = adj + int'(r.ply);
					if (adj < -mt)
						adj = adj - int'(r.ply);
					adj = clamp16(adj);
					tt_key[slot] = r.key;
					tt_score[slot] = adj[15:0];
					tt_depth[slot] = r.depth;
					tt_move[slot] = r.move;
					tt_bound[slot] = r.bound;
					tt_valid[slot] = 1'b1;
					res.written = 1'b1;
				end
			end
			OP_AGE: begin
				n_walks++;
				for (int i = 0; i < ENTRIES; i++)
					tt_valid[i] = 1'b0;
			end
			default: begin
				n_walks++;
				for (int i = 0; i < ENTRIES; i++) begin
					tt_key[i] = '0;
					tt_score[i] = '0;
					tt_depth[i] = '0;
					tt_move[i] = '0;
					tt_bound[i] = '0;
					tt_valid[i] = 1'b0;
				end
			end
		endcase
		return res;
	endfunction

	function automatic tt_req_t make_req(input op_t op, input logic [63:0] key, input int ply,
			input int depth, input int alpha, input int beta, input int value,
			input logic [1:0] bound, input int move);
		tt_req_t r;
		r.op = op;
		r.key = key;
		r.ply = ply[6:0];
		r.depth = depth[6:0];
		r.alpha = alpha[15:0];
		r.beta = beta[15:0];
		r.value = value[15:0];
		r.bound = bound;
		r.move = move[15:0];
		return r;
	endfunction

	function automatic logic signed [15:0] random_score();
		int s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: s = int'($urandom_range(0, 600)) - 300;
			4, 5: s = int'($urandom_range(0, 65535)) - 32768;
			6: s = int'($urandom_range(29000, 32767));
			7: s = -int'($urandom_range(29000, 32768));
			8: s = $urandom_range(0, 1) ? 32767 : -32768;
			default: begin
				s = int'(mate_thr) + int'($urandom_range(0, 4)) - 2;
				if ($urandom_range(0, 1))
					s = -s;
			end
		endcase
		return s[15:0];
	endfunction

	function automatic tt_req_t random_req();
		tt_req_t r;
		int pick;
		pick = $urandom_range(0, 999);
		if (pick < 4 && walks_left > 0) begin
			walks_left--;
			r.op = (pick < 2) ? OP_AGE : OP_CLEAR;
		end else if (pick < 500) begin
			r.op = OP_STORE;
		end else begin
			r.op = OP_PROBE;
		end
		if ($urandom_range(0, 99) < 15)
			r.key = {$urandom, $urandom};
		else if (r.op == OP_PROBE && $urandom_range(0, 99) < 40)
			r.key = last_stored_key;
		else
			r.key = key_pool[$urandom_range(0, 23)];
		if (r.op == OP_STORE)
			last_stored_key = r.key;
		r.ply = 7'($urandom_range(0, 127));
		r.depth = 7'($urandom_range(0, 127));
		r.alpha = random_score();
		r.beta = random_score();
		r.value = random_score();
		r.bound = ($urandom_range(0, 99) < 6) ? BOUND_ODD : 2'($urandom_range(0, 2));
		r.move = 16'($urandom);
		return r;
	endfunction

	task automatic queue_req(input tt_req_t r);
		request_q.push_back(r);
		n_queued++;
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || due_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DAT_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_MATE_LIMIT)
			mate_thr = val[14:0];
		else if (idx == CFG_INDEX_BITS)
			idx_bits = val[4:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin : drv
		tt_req_t nxt;
		if (!s_tvalid || item_taken) begin
			if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = request_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {2'b00, nxt.move, nxt.value, nxt.beta, nxt.alpha, nxt.depth,
					nxt.ply, nxt.key};
				s_tuser <= {nxt.bound, nxt.op};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : mon
		tt_req_t got;
		tt_res_t want;
		item_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				got.op = op_t'(s_tuser[1:0]);
				got.bound = s_tuser[3:2];
				got.key = s_tdata[63:0];
				got.ply = s_tdata[70:64];
				got.depth = s_tdata[77:71];
				got.alpha = s_tdata[93:78];
				got.beta = s_tdata[109:94];
				got.value = s_tdata[125:110];
				got.move = s_tdata[141:126];
				due_results.push_back(table_access(got));
				n_accepted++;
			end
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("result item with nothing pending");
					fails++;
				end else begin
					want = due_results.pop_front();
					n_hits += want.move_valid;
					n_scored += want.score_valid;
					n_written += want.written;
					if (m_tuser[0] !== want.score_valid) begin
						$error("score_valid: expected %0d, got %0d", want.score_valid, m_tuser[0]);
						fails++;
					end
					if (m_tdata[15:0] !== want.score) begin
						$error("score: expected %0d, got %0d", want.score,
							$signed(m_tdata[15:0]));
						fails++;
					end
					if (m_tuser[1] !== want.move_valid) begin
						$error("move_valid: expected %0d, got %0d", want.move_valid, m_tuser[1]);
						fails++;
					end
					if (m_tdata[31:16] !== want.move_out) begin
						$error("move_out: expected %h, got %h", want.move_out, m_tdata[31:16]);
						fails++;
					end
					if (m_tuser[2] !== want.written) begin
						$error("written: expected %0d, got %0d", want.written, m_tuser[2]);
						fails++;
					end
				end
			end
		end
	end

	initial begin : stim
		for (int i = 0; i < 24; i++) begin
			key_pool[i] = {$urandom, $urandom};
			if (i < 12)
				key_pool[i][15:0] = 16'($urandom_range(0, 15));
		end
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		queue_req(make_req(OP_PROBE, KEY_A, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_STORE, KEY_A, 5, 10, 0, 0, 100, BOUND_EXACT, 16'hffff));
		queue_req(make_req(OP_PROBE, KEY_A, 5, 10, 0, 0, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_PROBE, KEY_A, 5, 11, 0, 0, 0, BOUND_EXACT, 0));
		// shallower store is refused
		queue_req(make_req(OP_STORE, KEY_A, 0, 5, 0, 0, -7, BOUND_EXACT, 1));
		// mate score saturates on store
		queue_req(make_req(OP_STORE, KEY_A, 127, 10, 0, 0, 32767, BOUND_EXACT, 2));
		queue_req(make_req(OP_PROBE, KEY_A, 3, 0, 0, 0, 0, BOUND_EXACT, 0));
		// colliding key replaces
		queue_req(make_req(OP_STORE, KEY_AC, 127, 127, 0, 0, -32768, BOUND_UPPER, 0));
		queue_req(make_req(OP_PROBE, KEY_AC, 127, 127, 32767, -32768, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_PROBE, KEY_AC, 0, 1, -32768, 32767, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_PROBE, KEY_A, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_STORE, KEY_B, 0, 20, 0, 0, 50, BOUND_LOWER, 16'h1234));
		queue_req(make_req(OP_PROBE, KEY_B, 0, 20, 0, 40, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_PROBE, KEY_B, 0, 20, 0, 60, 0, BOUND_EXACT, 0));
		// bound kind three gives a move but no score
		queue_req(make_req(OP_STORE, KEY_Z, 0, 0, 0, 0, 0, BOUND_ODD, 16'h8001));
		queue_req(make_req(OP_PROBE, KEY_Z, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_STORE, KEY_Z, 7, 127, 0, 0, -31000, BOUND_EXACT, 16'h7ffe));
		queue_req(make_req(OP_PROBE, KEY_Z, 7, 127, 0, 0, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_AGE, KEY_Z, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_PROBE, KEY_B, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
		// replacement test ignores the valid bit
		queue_req(make_req(OP_STORE, KEY_B, 0, 0, 0, 0, 0, BOUND_EXACT, 3));
		queue_req(make_req(OP_PROBE, KEY_B, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_CLEAR, KEY_Z, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
		queue_req(make_req(OP_STORE, KEY_B, 0, 0, 0, 0, -1, BOUND_EXACT, 4));
		queue_req(make_req(OP_PROBE, KEY_B, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_MATE_LIMIT, phase_mt[ph]);
			write_reg(CFG_INDEX_BITS, phase_ib[ph]);
			send_idle_pct = (ph % 4 == 1) ? 54 : (ph % 4 == 3) ? 35 : 0;
			recv_stall_pct = (ph % 4 == 2) ? 54 : (ph % 4 == 3) ? 35 : 0;
			repeat (165)
				queue_req(random_req());
			wait_drained();
		end
		repeat (20) @(negedge clk);

		$display("Covered %0d items over 9 register settings and 4 idle patterns.", n_queued);
		$display("%0d probe hits (%0d with score), %0d stores written, %0d table walks.",
			n_hits, n_scored, n_written, n_walks);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
